[hdl/tmd_pkg.sv]
// Shared types and constants for the triangular membership degree block.
// No dependencies; imported by tmd_div_step, triangular_membership_degree and the bench.
package tmd_pkg;

  // Fixed field widths of the item payload
  localparam int DEGREE_W  = 16;
  localparam int CLIP_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_FOOT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_FOOT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_POINT = 2'd2;

  // Per-item control carried alongside the divider data
  typedef struct packed {
    logic              in_tri;    // sample lies on one side of the triangle
    logic              zero_den;  // zero-width side, forces full membership
    logic [CLIP_W-1:0] clip;      // clip level of the item
  } tmd_ctrl_t;

endpackage

[hdl/triangular_membership_degree.sv]
// Triangular fuzzy membership degree, pipelined.
// FRACTION_BITS + 3 register stages: stage 0, one register stage per quotient bit of
// the divider, and the output register. One item per cycle while the output is not
// held; the whole pipeline holds while a result waits at the output register.
// Reset (rst_ni low, asynchronous) clears all valid bits and the three
// triangle registers to 0.
module triangular_membership_degree #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 15
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tmd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]           cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  input  logic [tmd_pkg::CLIP_W-1:0]       clip_level_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tmd_pkg::DEGREE_W-1:0]     degree_o
);
  import tmd_pkg::*;

  localparam int DW    = SAMPLE_BITS + 1;
  localparam int QW    = FRACTION_BITS + 1;
  localparam int NSTEP = QW;
  localparam int EW    = (QW > DEGREE_W) ? QW : DEGREE_W;

  // Triangle registers
  logic signed [SAMPLE_BITS-1:0] left_foot_q;
  logic signed [SAMPLE_BITS-1:0] right_foot_q;
  logic signed [SAMPLE_BITS-1:0] peak_point_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_foot_q  <= '0;
      right_foot_q <= '0;
      peak_point_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEFT_FOOT:  left_foot_q  <= cfg_wdata_i;
        CFG_RIGHT_FOOT: right_foot_q <= cfg_wdata_i;
        CFG_PEAK_POINT: peak_point_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless the output is held
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 0: side select, numerator and divisor
  logic signed [DW-1:0] xs, as_w, bs_w, cs_w;
  logic signed [DW-1:0] x_m_a, c_m_a, b_m_x, b_m_c;
  logic                 rise, fall;
  logic [DW-1:0]        num_d, den_d;
  tmd_ctrl_t            ctrl_d;

  always_comb begin
    xs    = {sample_i[SAMPLE_BITS-1], sample_i};
    as_w  = {left_foot_q[SAMPLE_BITS-1], left_foot_q};
    bs_w  = {right_foot_q[SAMPLE_BITS-1], right_foot_q};
    cs_w  = {peak_point_q[SAMPLE_BITS-1], peak_point_q};
    x_m_a = xs - as_w;
    c_m_a = cs_w - as_w;
    b_m_x = bs_w - xs;
    b_m_c = bs_w - cs_w;
    rise  = (xs >= as_w) && (xs <= cs_w);
    fall  = !rise && (xs >= cs_w) && (xs <= bs_w);
    num_d = rise ? x_m_a : b_m_x;
    den_d = rise ? c_m_a : b_m_c;
    ctrl_d.in_tri   = rise || fall;
    ctrl_d.zero_den = (rise || fall) && (den_d == '0);
    ctrl_d.clip     = clip_level_i;
  end

  logic          s0_valid_q;
  logic [DW-1:0] s0_num_q, s0_den_q;
  tmd_ctrl_t     s0_ctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_num_q  <= num_d;
      s0_den_q  <= den_d;
      s0_ctrl_q <= ctrl_d;
    end
  end

  // Restoring divider, one quotient bit per stage
  logic [NSTEP:0] valid_w;
  logic [DW-1:0]  rem_w  [NSTEP+1];
  logic [DW-1:0]  den_w  [NSTEP+1];
  logic [QW-1:0]  quo_w  [NSTEP+1];
  tmd_ctrl_t      ctrl_w [NSTEP+1];

  assign valid_w[0] = s0_valid_q;
  assign rem_w[0]   = s0_num_q;
  assign den_w[0]   = s0_den_q;
  assign quo_w[0]   = '0;
  assign ctrl_w[0]  = s0_ctrl_q;

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    tmd_div_step #(
      .DW       (DW),
      .QW       (QW),
      .SHIFT_EN (i != 0)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_w[i]),
      .rem_i   (rem_w[i]),
      .den_i   (den_w[i]),
      .quo_i   (quo_w[i]),
      .ctrl_i  (ctrl_w[i]),
      .valid_o (valid_w[i+1]),
      .rem_o   (rem_w[i+1]),
      .den_o   (den_w[i+1]),
      .quo_o   (quo_w[i+1]),
      .ctrl_o  (ctrl_w[i+1])
    );
  end

  // Output stage: zero-width fix, outside zeroing, clip
  logic [QW-1:0]       dq;
  logic [EW-1:0]       d_ext, clip_ext, dsel;
  logic [DEGREE_W-1:0] degree_q;

  always_comb begin
    dq       = ctrl_w[NSTEP].zero_den ? {1'b1, {FRACTION_BITS{1'b0}}} : quo_w[NSTEP];
    d_ext    = EW'(dq);
    clip_ext = EW'(ctrl_w[NSTEP].clip);
    if (!ctrl_w[NSTEP].in_tri) begin
      dsel = '0;
    end else if (clip_ext < d_ext) begin
      dsel = clip_ext;
    end else begin
      dsel = d_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_w[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      degree_q <= dsel[DEGREE_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign degree_o    = degree_q;

  // Checks
  a_stall_holds_valids : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_w))
    else $error("pipeline valid bits moved during a stall");

  a_stall_holds_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(degree_q) && out_valid_q)
    else $error("held result changed during a stall");

  a_zero_den_in_tri : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid_q && s0_ctrl_q.zero_den |-> s0_ctrl_q.in_tri)
    else $error("zero-width flag set outside the triangle");

  a_final_rem_below_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_w[NSTEP] && ctrl_w[NSTEP].in_tri && !ctrl_w[NSTEP].zero_den
      |-> rem_w[NSTEP] < den_w[NSTEP])
    else $error("divider remainder not below divisor");

endmodule

[hdl/tmd_div_step.sv]
// One registered step of the restoring divider: yields one quotient bit.
// Depends on tmd_pkg (tmd_ctrl_t).
module tmd_div_step #(
  parameter int DW       = 17,
  parameter int QW       = 16,
  parameter bit SHIFT_EN = 1'b1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [DW-1:0]      rem_i,
  input  logic [DW-1:0]      den_i,
  input  logic [QW-1:0]      quo_i,
  input  tmd_pkg::tmd_ctrl_t ctrl_i,
  output logic               valid_o,
  output logic [DW-1:0]      rem_o,
  output logic [DW-1:0]      den_o,
  output logic [QW-1:0]      quo_o,
  output tmd_pkg::tmd_ctrl_t ctrl_o
);
  import tmd_pkg::*;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_d;
  logic [QW-1:0] quo_d;
  logic          valid_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [QW-1:0] quo_q;
  tmd_ctrl_t     ctrl_q;

  // Trial subtract of the (shifted) partial remainder
  always_comb begin
    trial = SHIFT_EN ? {rem_i, 1'b0} : {1'b0, rem_i};
    diff  = trial - {1'b0, den_i};
    ge    = (trial >= {1'b0, den_i});
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    quo_d = {quo_i[QW-2:0], ge};
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Data registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      quo_q  <= quo_d;
      ctrl_q <= ctrl_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign ctrl_o  = ctrl_q;

endmodule

[bench/tmd_degree_checker.sv]
// Checker for triangular_membership_degree: tracks register writes, predicts the degree of
// every accepted sample and compares it with the degree items the block hands out.
// Depends on tmd_pkg for the field widths and register indexes.
module tmd_degree_checker #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 15
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tmd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]           cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  input  logic [tmd_pkg::CLIP_W-1:0]       clip_level_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [tmd_pkg::DEGREE_W-1:0]     degree_i,
  output int                               mismatch_count_o,
  output int                               pending_o
);
  import tmd_pkg::*;

  localparam longint FULL_DEGREE = longint'(1) << FRACTION_BITS;

  // One accepted sample and the degree it must produce
  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CLIP_W-1:0]             clip;
    logic [DEGREE_W-1:0]           degree;
  } pending_degree_t;

  pending_degree_t pending_degree_q[$];
  pending_degree_t oldest;
  int              mismatch_total = 0;

  // Our own copy of the triangle registers
  logic signed [SAMPLE_BITS-1:0] left_foot;
  logic signed [SAMPLE_BITS-1:0] right_foot;
  logic signed [SAMPLE_BITS-1:0] peak_point;

  // Membership degree of x in triangle (a, c, b), clipped inside the triangle
  function automatic logic [DEGREE_W-1:0] triangle_degree(
    input logic signed [SAMPLE_BITS-1:0] x,
    input logic [CLIP_W-1:0]             clip,
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b,
    input logic signed [SAMPLE_BITS-1:0] c
  );
    longint xv, av, bv, cv, num, den, deg, clip_v;
    bit     on_side;
    xv      = x;
    av      = a;
    bv      = b;
    cv      = c;
    clip_v  = clip;
    deg     = 0;
    num     = 0;
    den     = 0;
    on_side = 1'b0;
    // rising side is tried first
    if (xv >= av && xv <= cv) begin
      num     = xv - av;
      den     = cv - av;
      on_side = 1'b1;
    end else if (xv >= cv && xv <= bv) begin
      num     = bv - xv;
      den     = bv - cv;
      on_side = 1'b1;
    end
    if (on_side) begin
      // zero-width side means full membership
      deg = (den == 0) ? FULL_DEGREE : (num << FRACTION_BITS) / den;
      if (clip_v < deg) deg = clip_v;
    end
    return deg[DEGREE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] degree mismatch: %s", $realtime, what);
    mismatch_total++;
  endtask

  // Compare outputs first, then record new samples, then apply writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_foot        <= '0;
      right_foot       <= '0;
      peak_point       <= '0;
      pending_degree_q.delete();
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_degree_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item, degree %0d", degree_i));
        end else begin
          oldest = pending_degree_q.pop_front();
          if (degree_i !== oldest.degree) begin
            report_mismatch($sformatf("sample %0d clip %0d: want %0d, got %0d",
                                      oldest.sample, oldest.clip, oldest.degree, degree_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_degree_q.push_back('{sample_i, clip_level_i,
            triangle_degree(sample_i, clip_level_i, left_foot, right_foot, peak_point)});
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LEFT_FOOT:  left_foot  <= cfg_wdata_i;
          CFG_RIGHT_FOOT: right_foot <= cfg_wdata_i;
          CFG_PEAK_POINT: peak_point <= cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o        <= pending_degree_q.size();
      mismatch_count_o <= mismatch_total;
    end
  end

endmodule

[bench/tb.sv]
// Top of the triangular_membership_degree bench: clock, reset, register setup and samples,
// random stalls on the result side, and the final verdict.
// Depends on tmd_pkg, the block itself and tmd_degree_checker.
module tb;
  import tmd_pkg::*;

  localparam int SAMPLE_BITS     = 16;
  localparam int FRACTION_BITS   = 15;
  localparam int LATENCY         = FRACTION_BITS + 3;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int SAMPLE_MIN      = -(1 << (SAMPLE_BITS - 1));
  localparam int SAMPLE_MAX      = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int FULL_DEGREE     = 1 << FRACTION_BITS;
  localparam int CLIP_MAX        = (1 << CLIP_W) - 1;

  // index with no register behind it, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {
    TRI_EXTREME,
    TRI_SORTED,
    TRI_NARROW,
    TRI_SCRAMBLED,
    TRI_DEGENERATE
  } triangle_kind_e;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_idx     = '0;
  logic [SAMPLE_BITS-1:0]        cfg_wdata   = '0;
  logic                          in_valid    = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample      = '0;
  logic [CLIP_W-1:0]             clip_level  = '0;
  logic                          out_valid;
  logic                          out_ready   = 1'b0;
  logic [DEGREE_W-1:0]           degree;
  int                            mismatch_count;
  int                            pending_count;
  int                            cycle_count = 0;

  // triangle currently loaded, used to aim samples
  int cur_left, cur_right, cur_peak;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  triangular_membership_degree #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_i    (sample),
    .clip_level_i(clip_level),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .degree_o    (degree)
  );

  tmd_degree_checker #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .sample_i        (sample),
    .clip_level_i    (clip_level),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .degree_i        (degree),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_count)
  );

  function automatic int clamp_sample(input int v);
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    return v;
  endfunction

  function automatic int rand_sample();
    return $urandom_range(SAMPLE_MAX - SAMPLE_MIN) + SAMPLE_MIN;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Samples aimed around the loaded triangle, with exact corners and full-range noise
  function automatic int pick_sample();
    int r, lo, hi;
    r  = $urandom_range(99);
    lo = cur_left;
    hi = cur_left;
    if (cur_right < lo) lo = cur_right;
    if (cur_peak < lo)  lo = cur_peak;
    if (cur_right > hi) hi = cur_right;
    if (cur_peak > hi)  hi = cur_peak;
    if (r < 4)  return cur_left;
    if (r < 8)  return cur_right;
    if (r < 12) return cur_peak;
    if (r < 75) return clamp_sample(lo - 8 + $urandom_range(hi - lo + 16));
    return rand_sample();
  endfunction

  function automatic int pick_clip();
    int r;
    r = $urandom_range(99);
    if (r < 45) return FULL_DEGREE;
    if (r < 65) return $urandom_range(CLIP_MAX);
    if (r < 90) return $urandom_range(FULL_DEGREE);
    if (r < 94) return 0;
    if (r < 97) return CLIP_MAX;
    return FULL_DEGREE - 1;
  endfunction

  task automatic pick_triangle(input triangle_kind_e kind, output int lf, output int rf,
                               output int pk);
    int t, p;
    lf = rand_sample();
    rf = rand_sample();
    pk = rand_sample();
    case (kind)
      TRI_EXTREME: begin
        case ($urandom_range(3))
          0: begin lf = SAMPLE_MIN; rf = SAMPLE_MAX; pk = 0;          end
          1: begin lf = SAMPLE_MIN; rf = SAMPLE_MAX; pk = SAMPLE_MIN; end
          2: begin lf = SAMPLE_MIN; rf = SAMPLE_MAX; pk = SAMPLE_MAX; end
          default: begin lf = SAMPLE_MAX; rf = SAMPLE_MIN; pk = 0;    end
        endcase
      end
      TRI_SORTED: begin
        // order as left <= peak <= right
        if (lf > pk) begin t = lf; lf = pk; pk = t; end
        if (pk > rf) begin t = pk; pk = rf; rf = t; end
        if (lf > pk) begin t = lf; lf = pk; pk = t; end
      end
      TRI_NARROW: begin
        lf = clamp_sample(pk - $urandom_range(64));
        rf = clamp_sample(pk + $urandom_range(64));
      end
      TRI_DEGENERATE: begin
        p = rand_sample();
        case ($urandom_range(2))
          0: begin lf = p; pk = p; rf = clamp_sample(p + $urandom_range(200)); end
          1: begin rf = p; pk = p; lf = clamp_sample(p - $urandom_range(200)); end
          default: begin lf = p; rf = p; pk = p; end
        endcase
      end
      default: ;
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(input int s, input int clip, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    sample     <= s[SAMPLE_BITS-1:0];
    clip_level <= clip[CLIP_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Let every outstanding degree come back, then load a new triangle
  task automatic load_triangle(input int lf, input int rf, input int pk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_LEFT_FOOT;
    cfg_wdata <= lf[SAMPLE_BITS-1:0];
    @(negedge clk);
    cfg_idx   <= CFG_RIGHT_FOOT;
    cfg_wdata <= rf[SAMPLE_BITS-1:0];
    @(negedge clk);
    cfg_idx   <= CFG_PEAK_POINT;
    cfg_wdata <= pk[SAMPLE_BITS-1:0];
    if ($urandom_range(1) == 0) begin
      @(negedge clk);
      cfg_idx   <= CFG_UNUSED;
      cfg_wdata <= SAMPLE_BITS'($urandom);
    end
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_left  = lf;
    cur_right = rf;
    cur_peak  = pk;
  endtask

  // Result side: runs of ready broken by stalls, now and then a long clean stretch
  initial begin
    int run, stall, r;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      run = ($urandom_range(9) == 0) ? $urandom_range(400, 200) : $urandom_range(24, 1);
      out_ready <= 1'b1;
      repeat (run) @(negedge clk);
      r = $urandom_range(99);
      stall = (r < 40) ? 0 : (r < 90) ? $urandom_range(3, 1) : $urandom_range(40, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    int  lf, rf, pk, n, phase;
    bit  burst;
    cur_left  = 0;
    cur_right = 0;
    cur_peak  = 0;
    burst     = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset triangle is a single point at zero
    send_item(0, FULL_DEGREE, 0);
    send_item(0, 0, pick_gap());
    send_item(1, FULL_DEGREE, 0);
    send_item(-1, FULL_DEGREE, pick_gap());
    send_item(SAMPLE_MIN, CLIP_MAX, 0);
    send_item(SAMPLE_MAX, CLIP_MAX, 0);

    // widest triangle: feet on the range ends
    load_triangle(SAMPLE_MIN, SAMPLE_MAX, 0);
    send_item(SAMPLE_MIN, FULL_DEGREE, 0);
    send_item(SAMPLE_MAX, FULL_DEGREE, 0);
    send_item(0, FULL_DEGREE, 0);
    send_item(-16384, FULL_DEGREE, pick_gap());
    send_item(16384, FULL_DEGREE - 1, 0);
    send_item(100, 0, 0);
    send_item(-100, CLIP_MAX, 0);

    // peak on the right foot: empty-width falling side
    load_triangle(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX);
    send_item(SAMPLE_MAX, FULL_DEGREE, 0);
    send_item(0, 100, 0);

    // all three points equal: both sides zero width, clip still applies
    load_triangle(10, 10, 10);
    send_item(10, FULL_DEGREE, 0);
    send_item(10, 5, 0);
    send_item(9, FULL_DEGREE, 0);
    send_item(11, FULL_DEGREE, 0);

    // feet in the wrong order: both sides empty
    load_triangle(100, -100, 0);
    send_item(0, FULL_DEGREE, 0);
    send_item(50, FULL_DEGREE, 0);
    send_item(-50, FULL_DEGREE, 0);
    send_item(100, FULL_DEGREE, 0);

    // random phases, one triangle each
    for (phase = 0; phase < PHASES; phase++) begin
      pick_triangle(triangle_kind_e'(phase % 5), lf, rf, pk);
      load_triangle(lf, rf, pk);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 25 == 0) burst = ($urandom_range(3) == 0);
        send_item(pick_sample(), pick_clip(), burst ? 0 : pick_gap());
      end
    end

    // drain and let the pipeline settle
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4 * LATENCY) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
